// ----- hdl/stepper_step_dir_generator_unit_defines.svh -----
// Assertion macros for the checker file of the step/dir generator.
// No dependencies.
`ifndef STEPPER_STEP_DIR_GENERATOR_UNIT_DEFINES_SVH
`define STEPPER_STEP_DIR_GENERATOR_UNIT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define STPSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define STPSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/stpsd_pkg.sv -----
// Package for the step/dir generator: widths, request and register codes,
// and the structs passed between modules. No dependencies.
package stpsd_pkg;

  localparam int unsigned PosBits     = 24;
  localparam int unsigned TimerBits   = 16;
  localparam int unsigned ReqBits     = 3;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = (PosBits > TimerBits) ? PosBits : TimerBits;

  typedef logic signed [PosBits-1:0] pos_t;
  typedef logic [TimerBits-1:0]      timer_t;

  typedef enum logic [ReqBits-1:0] {
    ReqTick      = 3'd0,
    ReqSetTarget = 3'd1,
    ReqStop      = 3'd2,
    ReqSetEnable = 3'd3,
    ReqLoadPos   = 3'd4
  } req_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgStepPeriod   = 3'd0,
    CfgEstopHoldoff = 3'd1,
    CfgMinPosition  = 3'd2,
    CfgMaxPosition  = 3'd3,
    CfgEstopLevel   = 3'd4
  } cfg_idx_e;

  localparam timer_t StepPeriodRst = timer_t'(100);
  localparam timer_t HoldoffRst    = timer_t'(100);
  localparam pos_t   PosMin        = pos_t'({1'b1, {(PosBits-1){1'b0}}});
  localparam pos_t   PosMax        = pos_t'({1'b0, {(PosBits-1){1'b1}}});

  typedef struct packed {
    timer_t ticks_per_step;
    timer_t estop_holdoff;
    pos_t   min_position;
    pos_t   max_position;
    logic   estop_level;
  } cfg_t;

  typedef struct packed {
    logic [ReqBits-1:0] req_type;
    pos_t               position_value;
    logic               enable_value;
    logic               estop_pin;
  } req_t;

  typedef struct packed {
    logic step_out;
    logic dir_out;
    logic drive_enable;
    logic estop_indicator;
    logic moving;
    pos_t position;
    logic accepted;
  } res_t;

endpackage

// ----- hdl/stpsd_cfg.sv -----
// Configuration register file of the step/dir generator.
// Depends on stpsd_pkg.
module stpsd_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  wr_en_i,
  input  logic [stpsd_pkg::CfgIdxBits-1:0]      wr_idx_i,
  input  logic [stpsd_pkg::CfgDataBits-1:0]     wr_data_i,
  output stpsd_pkg::cfg_t                       cfg_o
);
  import stpsd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_idx_i))
        CfgStepPeriod:   cfg_d.ticks_per_step = wr_data_i[TimerBits-1:0];
        CfgEstopHoldoff: cfg_d.estop_holdoff  = wr_data_i[TimerBits-1:0];
        CfgMinPosition:  cfg_d.min_position   = pos_t'(wr_data_i[PosBits-1:0]);
        CfgMaxPosition:  cfg_d.max_position   = pos_t'(wr_data_i[PosBits-1:0]);
        CfgEstopLevel:   cfg_d.estop_level    = wr_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_step <= StepPeriodRst;
      cfg_q.estop_holdoff  <= HoldoffRst;
      cfg_q.min_position   <= PosMin;
      cfg_q.max_position   <= PosMax;
      cfg_q.estop_level    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/stpsd_core.sv -----
// Motion state and per-request update of the step/dir generator.
// Depends on stpsd_pkg.
module stpsd_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  stpsd_pkg::req_t req_i,
  input  stpsd_pkg::cfg_t cfg_i,
  output stpsd_pkg::res_t res_o
);
  import stpsd_pkg::*;

  pos_t   cur_q, cur_d, tgt_q, tgt_d;
  logic   mov_q, mov_d, en_q, en_d, step_q, step_d, dir_q, dir_d, lit_q, lit_d;
  timer_t tc_q, tc_d, hold_q, hold_d;
  timer_t tc_inc;
  logic   in_rng, ok;
  pos_t   pos_nxt;

  assign in_rng = (req_i.position_value >= cfg_i.min_position) &&
                  (req_i.position_value <= cfg_i.max_position);
  assign tc_inc = tc_q + timer_t'(1);

  always_comb begin
    cur_d   = cur_q;
    tgt_d   = tgt_q;
    mov_d   = mov_q;
    en_d    = en_q;
    step_d  = step_q;
    dir_d   = dir_q;
    lit_d   = lit_q;
    tc_d    = tc_q;
    hold_d  = hold_q;
    ok      = 1'b1;
    pos_nxt = cur_q;
    unique case (req_i.req_type)
      ReqTick: begin
        if (req_i.estop_pin == cfg_i.estop_level) begin
          en_d   = 1'b0;
          mov_d  = 1'b0;
          tgt_d  = cur_q;
          hold_d = cfg_i.estop_holdoff;
          lit_d  = 1'b1;
        end else if (hold_q != '0) begin
          hold_d = hold_q - timer_t'(1);
          lit_d  = 1'b1;
        end else begin
          lit_d  = 1'b0;
        end
        dir_d   = tgt_d > cur_q;
        pos_nxt = dir_d ? cur_q + pos_t'(1) : cur_q - pos_t'(1);
        if (mov_d) begin
          tc_d = tc_inc;
          if (tc_inc == (cfg_i.ticks_per_step >> 1)) begin
            step_d = 1'b1;
          end else if (tc_inc >= cfg_i.ticks_per_step) begin
            step_d = 1'b0;
            tc_d   = '0;
            cur_d  = pos_nxt;
            if (pos_nxt == tgt_d) mov_d = 1'b0;
          end
        end else begin
          step_d = 1'b0;
          tc_d   = '0;
        end
      end
      ReqSetTarget: begin
        if (in_rng) begin
          tgt_d = req_i.position_value;
          mov_d = req_i.position_value != cur_q;
        end else begin
          ok = 1'b0;
        end
      end
      ReqStop: begin
        tgt_d = cur_q;
        mov_d = 1'b0;
      end
      ReqSetEnable: en_d = req_i.enable_value;
      ReqLoadPos: begin
        if (in_rng) begin
          cur_d  = req_i.position_value;
          tgt_d  = req_i.position_value;
          mov_d  = 1'b0;
          tc_d   = '0;
          step_d = 1'b0;
          en_d   = 1'b0;
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b1; // unused codes leave state alone
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      tgt_q  <= '0;
      mov_q  <= 1'b0;
      en_q   <= 1'b0;
      step_q <= 1'b0;
      dir_q  <= 1'b0;
      lit_q  <= 1'b0;
      tc_q   <= '0;
      hold_q <= '0;
    end else if (fire_i) begin
      cur_q  <= cur_d;
      tgt_q  <= tgt_d;
      mov_q  <= mov_d;
      en_q   <= en_d;
      step_q <= step_d;
      dir_q  <= dir_d;
      lit_q  <= lit_d;
      tc_q   <= tc_d;
      hold_q <= hold_d;
    end
  end

  // result reflects state after this request
  assign res_o.step_out        = step_d;
  assign res_o.dir_out         = dir_d;
  assign res_o.drive_enable    = en_d;
  assign res_o.estop_indicator = lit_d;
  assign res_o.moving          = mov_d;
  assign res_o.position        = cur_d;
  assign res_o.accepted        = ok;

endmodule

// ----- hdl/stepper_step_dir_generator_unit.sv -----
// Top level of the step/dir generator: input register, motion core, result
// register and configuration registers. Depends on stpsd_pkg, stpsd_cfg, stpsd_core.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_ready_o | req_type, position_value, enable, pin
//  out     | source    | out_valid_o/out_ready_i | step, dir, enable, estop, moving, ...
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request per clock sustained while results are taken. From input beat to
// result, a request passes the input register, then the core's update logic
// feeding the result register. A full result register that is not taken stalls the
// input register, which in turn drops in_ready_o. Reset clears all valid
// flags and motion state; configuration comes up at its defaults and is
// always writeable (cfg_ready_o held high).
module stepper_step_dir_generator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [stpsd_pkg::ReqBits-1:0]     req_type_i,
  input  logic signed [stpsd_pkg::PosBits-1:0] position_value_i,
  input  logic                              enable_value_i,
  input  logic                              estop_pin_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              step_out_o,
  output logic                              dir_out_o,
  output logic                              drive_enable_o,
  output logic                              estop_indicator_o,
  output logic                              moving_o,
  output logic signed [stpsd_pkg::PosBits-1:0] position_o,
  output logic                              accepted_o,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [stpsd_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [stpsd_pkg::CfgDataBits-1:0] cfg_data_i
);
  import stpsd_pkg::*;

  logic in_vld_q, out_vld_q;
  req_t in_req_q;
  res_t out_res_q, core_res;
  cfg_t cfg;
  logic adv, fire;

  // result register free (or emptying) this cycle
  assign adv        = !out_vld_q || out_ready_i;
  // request in the input register moves through the core
  assign fire       = in_vld_q && adv;
  assign in_ready_o = !in_vld_q || adv;
  assign cfg_ready_o = 1'b1;

  stpsd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  stpsd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .res_o  (core_res)
  );

  // input and result registers: valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q.req_type       <= req_type_i;
      in_req_q.position_value <= position_value_i;
      in_req_q.enable_value   <= enable_value_i;
      in_req_q.estop_pin      <= estop_pin_i;
    end
    if (fire) out_res_q <= core_res;
  end

  assign out_valid_o       = out_vld_q;
  assign step_out_o        = out_res_q.step_out;
  assign dir_out_o         = out_res_q.dir_out;
  assign drive_enable_o    = out_res_q.drive_enable;
  assign estop_indicator_o = out_res_q.estop_indicator;
  assign moving_o          = out_res_q.moving;
  assign position_o        = out_res_q.position;
  assign accepted_o        = out_res_q.accepted;

endmodule

// ----- hdl/stpsd_checker.sv -----
// Port-level checks on the step/dir generator, bound to its top level.
// Depends on stpsd_pkg and stepper_step_dir_generator_unit_defines.svh.
`include "stepper_step_dir_generator_unit_defines.svh"

module stpsd_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic                                 step_out_o,
  input logic                                 moving_o,
  input logic signed [stpsd_pkg::PosBits-1:0] position_o,
  input logic                                 accepted_o
);
  import stpsd_pkg::*;

  // a held result beat keeps its payload
  `STPSD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_o) && $stable(step_out_o) && $stable(accepted_o) && $stable(moving_o), "result beat changed while stalled")

  // input side only stalls behind a full result register
  `STPSD_ASSERT(a_no_idle_stall, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input stalled with empty result register")

  // nothing comes out on the first edge after reset
  `STPSD_ASSERT(a_reset_empty, clk_i, rst_ni, $past(!rst_ni) |-> !out_valid_o, "result valid straight after reset")

endmodule

bind stepper_step_dir_generator_unit stpsd_checker u_stpsd_checker (.*);

// ----- tb/tb_stepper_step_dir_generator_unit.sv -----
// Self-checking testbench for stepper_step_dir_generator_unit: directed and random
// request beats, an in-bench motion predictor and a per-field result check.
// Depends on stpsd_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_stepper_step_dir_generator_unit;
  import stpsd_pkg::*;

  // Request codes beyond the defined set; the block must ignore them.
  localparam logic [ReqBits-1:0] ReqUndefLo = 3'd5;
  localparam logic [ReqBits-1:0] ReqUndefHi = 3'd7;

  // Tracks the motion state and holds the pin levels due from the block,
  // oldest first. One result beat per request beat.
  class step_dir_tracker;
    timer_t period, holdoff;
    pos_t   lo_pos, hi_pos;
    logic   stop_level;
    pos_t   cur_pos, tgt_pos;
    timer_t ticks, hold_cnt;
    logic   moving_f, enabled_f, step_f, dir_f, lit_f;
    res_t   pending_pins[$];
    int     mismatches;

    function new();
      period     = StepPeriodRst;
      holdoff    = HoldoffRst;
      lo_pos     = PosMin;
      hi_pos     = PosMax;
      stop_level = 1'b0;
      cur_pos    = '0;
      tgt_pos    = '0;
      ticks      = '0;
      hold_cnt   = '0;
      moving_f   = 1'b0;
      enabled_f  = 1'b0;
      step_f     = 1'b0;
      dir_f      = 1'b0;
      lit_f      = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataBits-1:0] data);
      case (idx)
        CfgStepPeriod:   period     = data[TimerBits-1:0];
        CfgEstopHoldoff: holdoff    = data[TimerBits-1:0];
        CfgMinPosition:  lo_pos     = pos_t'(data[PosBits-1:0]);
        CfgMaxPosition:  hi_pos     = pos_t'(data[PosBits-1:0]);
        CfgEstopLevel:   stop_level = data[0];
        default: ;
      endcase
    endfunction

    // Accepted request beat: advance the state and queue the expected pins.
    function void take_request(logic [ReqBits-1:0] kind, pos_t pv, logic en, logic pin);
      res_t want;
      logic ok;
      logic fits;
      ok   = 1'b1;
      fits = (pv >= lo_pos) && (pv <= hi_pos);
      case (kind)
        ReqTick: begin
          // stop input first: it wins over any motion on this tick
          if (pin == stop_level) begin
            enabled_f = 1'b0;
            moving_f  = 1'b0;
            tgt_pos   = cur_pos;
            hold_cnt  = holdoff;
            lit_f     = 1'b1;
          end else if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 1'b1;
            lit_f    = 1'b1;
          end else begin
            lit_f = 1'b0;
          end
          dir_f = (tgt_pos > cur_pos);
          if (moving_f) begin
            ticks = ticks + 1'b1;
            if (ticks == (period >> 1)) begin
              step_f = 1'b1;
            end else if (ticks >= period) begin
              step_f  = 1'b0;
              ticks   = '0;
              cur_pos = dir_f ? cur_pos + 1'b1 : cur_pos - 1'b1;
              if (cur_pos == tgt_pos) moving_f = 1'b0;
            end
          end else begin
            step_f = 1'b0;
            ticks  = '0;
          end
        end
        ReqSetTarget: begin
          if (fits) begin
            tgt_pos  = pv;
            moving_f = (pv != cur_pos);
          end else begin
            ok = 1'b0;
          end
        end
        ReqStop: begin
          tgt_pos  = cur_pos;
          moving_f = 1'b0;
        end
        ReqSetEnable: enabled_f = en;
        ReqLoadPos: begin
          if (fits) begin
            cur_pos   = pv;
            tgt_pos   = pv;
            moving_f  = 1'b0;
            ticks     = '0;
            step_f    = 1'b0;
            enabled_f = 1'b0;
          end else begin
            ok = 1'b0;
          end
        end
        default: ;
      endcase
      want.step_out        = step_f;
      want.dir_out         = dir_f;
      want.drive_enable    = enabled_f;
      want.estop_indicator = lit_f;
      want.moving          = moving_f;
      want.position        = cur_pos;
      want.accepted        = ok;
      pending_pins.push_back(want);
    endfunction

    function void cmp_field(string field, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void match_pins(res_t got);
      res_t want;
      if (pending_pins.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_pins.pop_front();
      cmp_field("step_out", want.step_out, got.step_out);
      cmp_field("dir_out", want.dir_out, got.dir_out);
      cmp_field("drive_enable", want.drive_enable, got.drive_enable);
      cmp_field("estop_indicator", want.estop_indicator, got.estop_indicator);
      cmp_field("moving", want.moving, got.moving);
      cmp_field("position", want.position, got.position);
      cmp_field("accepted", want.accepted, got.accepted);
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [ReqBits-1:0]         req_type_i;
  logic signed [PosBits-1:0]  position_value_i;
  logic                       enable_value_i;
  logic                       estop_pin_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       step_out_o;
  logic                       dir_out_o;
  logic                       drive_enable_o;
  logic                       estop_indicator_o;
  logic                       moving_o;
  logic signed [PosBits-1:0]  position_o;
  logic                       accepted_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CfgIdxBits-1:0]      cfg_index_i;
  logic [CfgDataBits-1:0]     cfg_data_i;

  step_dir_tracker motion = new();

  // Quiet stretches: while one of these counts down, that side never idles.
  int send_quiet = 0;
  int sink_quiet = 0;

  stepper_step_dir_generator_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .position_value_i  (position_value_i),
    .enable_value_i    (enable_value_i),
    .estop_pin_i       (estop_pin_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .step_out_o        (step_out_o),
    .dir_out_o         (dir_out_o),
    .drive_enable_o    (drive_enable_o),
    .estop_indicator_o (estop_indicator_o),
    .moving_o          (moving_o),
    .position_o        (position_o),
    .accepted_o        (accepted_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random idle gap before the next beat, with the odd quiet stretch.
  function automatic int idle_draw(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 40) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Target or load value: mostly a short hop from the current position so
  // moves complete, some around the window limits, some anywhere at all.
  function automatic pos_t pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return pos_t'($urandom);
    if (r == 1)
      return (($urandom_range(0, 1) != 0) ? motion.lo_pos : motion.hi_pos)
             + pos_t'($urandom_range(0, 2)) - pos_t'(1);
    return motion.cur_pos + pos_t'($urandom_range(0, 16)) - pos_t'(8);
  endfunction

  // One request beat. Valid drops only across a gap, so back-to-back beats
  // keep it high and just swap the payload.
  task automatic push_request(input logic [ReqBits-1:0] kind, input pos_t pv,
                              input logic en, input logic pin);
    int gap;
    gap = idle_draw(send_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= kind;
    position_value_i <= pv;
    enable_value_i   <= en;
    estop_pin_i      <= pin;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    motion.take_request(kind, pv, en, pin);
  endtask

  // Waits on the clock before it first checks the queue, so valid never sees two updates in a step.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (motion.pending_pins.size() != 0);
  endtask

  // Writes all five registers once the block has gone idle.
  task automatic reconfigure(input timer_t period, input timer_t holdoff,
                             input pos_t lo, input pos_t hi, input logic level);
    logic [CfgDataBits-1:0] value [5];
    value[CfgStepPeriod]   = CfgDataBits'(period);
    value[CfgEstopHoldoff] = CfgDataBits'(holdoff);
    value[CfgMinPosition]  = CfgDataBits'(lo);
    value[CfgMaxPosition]  = CfgDataBits'(hi);
    value[CfgEstopLevel]   = CfgDataBits'(level);
    wait_drained();
    // two-stage pipe: let it settle before touching the registers
    repeat (4) @(posedge clk_i);
    for (int i = 0; i <= CfgEstopLevel; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxBits'(i);
      cfg_data_i  <= value[i];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      motion.write_reg(cfg_idx_e'(i), value[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic: mostly ticks with the stop released, so moves run to the
  // end; also new targets and enables, now and then a stop, a reload, junk codes, or a full drain.
  task automatic random_items(input int count);
    int   r;
    logic pin;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 79) == 0) wait_drained();
      r   = $urandom_range(0, 99);
      pin = ($urandom_range(0, 15) == 0) ? motion.stop_level : ~motion.stop_level;
      if (r < 66)
        push_request(ReqTick, pos_t'($urandom), 1'($urandom), pin);
      else if (r < 80)
        push_request(ReqSetTarget, pick_position(), 1'($urandom), 1'($urandom));
      else if (r < 88)
        push_request(ReqSetEnable, pos_t'($urandom), ($urandom_range(0, 6) != 0),
                     1'($urandom));
      else if (r < 92)
        push_request(ReqStop, pos_t'($urandom), 1'($urandom), 1'($urandom));
      else if (r < 97)
        push_request(ReqLoadPos, pick_position(), 1'($urandom), 1'($urandom));
      else
        push_request(ReqBits'($urandom_range(ReqUndefLo, ReqUndefHi)), pos_t'($urandom),
                     1'($urandom), 1'($urandom));
    end
  endtask

  // New settings, park the motor mid-window where that is possible, then traffic.
  task automatic run_phase(input timer_t period, input timer_t holdoff, input pos_t lo,
                           input pos_t hi, input logic level, input int count);
    reconfigure(period, holdoff, lo, hi, level);
    if (lo <= hi)
      push_request(ReqLoadPos, pos_t'((int'(lo) + int'(hi)) / 2), 1'b0, ~level);
    random_items(count);
  endtask

  // Result side: random back-pressure, every beat checked against the tracker.
  initial begin : result_sink
    res_t got;
    int   stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_draw(sink_quiet);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.step_out        = step_out_o;
      got.dir_out         = dir_out_o;
      got.drive_enable    = drive_enable_o;
      got.estop_indicator = estop_indicator_o;
      got.moving          = moving_o;
      got.position        = position_o;
      got.accepted        = accepted_o;
      motion.match_pins(got);
    end
  end

  initial begin : stimulus
    pos_t centre;
    int   half;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    req_type_i       <= ReqTick;
    position_value_i <= '0;
    enable_value_i   <= 1'b0;
    estop_pin_i      <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= CfgStepPeriod;
    cfg_data_i       <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: stop is active low, hold-off 100, full range.
    push_request(ReqTick, PosMax, 1'b1, 1'b0);          // stop taken, drive off
    push_request(ReqTick, PosMin, 1'b0, 1'b1);          // released, hold-off counts
    push_request(ReqSetEnable, '0, 1'b1, 1'b0);
    push_request(ReqSetTarget, '0, 1'b0, 1'b1);         // target equals position: no move
    push_request(ReqSetTarget, PosMax, 1'b1, 1'b0);
    push_request(ReqTick, '1, 1'b0, 1'b1);              // direction goes forward
    push_request(ReqStop, PosMin, 1'b1, 1'b1);
    push_request(ReqTick, '0, 1'b1, 1'b1);              // step level low after stop
    push_request(ReqSetTarget, PosMin, 1'b0, 1'b0);
    push_request(ReqTick, PosMax, 1'b0, 1'b0);          // stop mid-move
    push_request(ReqSetEnable, '0, 1'b1, 1'b0);         // enable obeyed during stop
    push_request(ReqTick, '0, 1'b1, 1'b0);              // ... and withdrawn again
    push_request(ReqLoadPos, PosMax, 1'b1, 1'b1);
    push_request(ReqLoadPos, PosMin, 1'b0, 1'b0);
    push_request(ReqLoadPos, '1, 1'b1, 1'b1);
    push_request(ReqLoadPos, '0, 1'b0, 1'b1);
    for (int k = ReqUndefLo; k <= ReqUndefHi; k++)
      push_request(ReqBits'(k), PosMax, 1'b1, 1'b1);
    push_request(ReqSetEnable, '1, 1'b0, 1'b1);

    // Narrow window, shortest period with a step pulse, no hold-off, stop active high.
    reconfigure(timer_t'(2), timer_t'(0), pos_t'(-4), pos_t'(4), 1'b1);
    push_request(ReqSetTarget, pos_t'(5), 1'b0, 1'b0);  // above max: refused
    push_request(ReqSetTarget, pos_t'(-5), 1'b0, 1'b0); // below min: refused
    push_request(ReqLoadPos, pos_t'(5), 1'b0, 1'b0);    // refused, nothing changes
    push_request(ReqSetTarget, pos_t'(4), 1'b1, 1'b0);
    repeat (3) push_request(ReqTick, '0, 1'b0, 1'b0);   // rise at half, step at full
    push_request(ReqTick, '0, 1'b0, 1'b1);              // lit for this tick only
    push_request(ReqTick, '0, 1'b0, 1'b0);

    run_phase(StepPeriodRst, HoldoffRst, PosMin, PosMax, 1'b0, 40);
    run_phase(timer_t'(2), timer_t'(0), pos_t'(-16), pos_t'(16), 1'b1, 120);
    run_phase(timer_t'(5), timer_t'(3), PosMin, PosMax, 1'b0, 100);
    // periods below two: no rise at all, and a step on every tick
    run_phase(timer_t'(0), timer_t'(2), pos_t'(-8), pos_t'(8), 1'b1, 30);
    run_phase(timer_t'(1), timer_t'(1), pos_t'(-8), pos_t'(8), 1'b0, 30);
    // min above max: every range-checked request refused
    run_phase(timer_t'(3), '1, pos_t'(5), pos_t'(-5), 1'b1, 30);
    run_phase('1, '1, PosMax - pos_t'(20), PosMax, 1'b0, 30);
    run_phase(timer_t'(2), timer_t'(5), PosMin, PosMin + pos_t'(12), 1'b1, 60);
    repeat (5) begin
      centre = pos_t'($urandom);
      half   = $urandom_range(4, 40);
      run_phase(timer_t'($urandom_range(2, 9)), timer_t'($urandom_range(0, 6)),
                centre - pos_t'(half), centre + pos_t'(half), 1'($urandom), 40);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (motion.mismatches == 0)
      $display("tb_stepper_step_dir_generator_unit: clean");
    else
      $display("tb_stepper_step_dir_generator_unit: errors");
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("tb_stepper_step_dir_generator_unit: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/stpsd_pkg.sv
hdl/stpsd_cfg.sv
hdl/stpsd_core.sv
hdl/stepper_step_dir_generator_unit.sv
hdl/stpsd_checker.sv
tb/tb_stepper_step_dir_generator_unit.sv
